### design/pcvs_pkg.sv
// Shared types and codes for the partitioned clock victim selector.
package pcvs_pkg;

  typedef enum logic [1:0] {
    REQ_CLAIM   = 2'd0,
    REQ_ACQUIRE = 2'd1,
    REQ_RELEASE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_VICTIM = 2'd1,
    STAT_PIN_SAT   = 2'd2,
    STAT_UNPINNED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] thread_sel;
    logic [9:0] target_entry;
  } in_item_t;

  typedef struct packed {
    status_e    status;
    logic [9:0] victim_index;
    logic       victim_was_occupied;
  } out_item_t;

  // Verdict of the entry evaluation unit for one examined entry.
  typedef struct packed {
    logic    take;
    logic    wr_en;
    logic    was_occ;
    status_e status;
  } eval_res_t;

endpackage

### design/pcvs_entry_ram.sv
// Entry state memory: one write port, one registered read port.
module pcvs_entry_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/pcvs_eval.sv
// Entry evaluation unit: decides take/skip, the status and the updated entry word.
module pcvs_eval #(
  parameter int COUNT_BITS = 8
) (
  input  logic [1:0]              op_i,
  input  logic [COUNT_BITS+1:0]   word_i,
  output pcvs_pkg::eval_res_t     res_o,
  output logic [COUNT_BITS+1:0]   word_o
);

  // word layout: {occupied, read mark, pin count}
  logic [COUNT_BITS-1:0] pin;
  logic                  mark;
  logic                  occ;

  assign pin  = word_i[COUNT_BITS-1:0];
  assign mark = word_i[COUNT_BITS];
  assign occ  = word_i[COUNT_BITS+1];

  always_comb begin
    res_o.take    = 1'b0;
    res_o.wr_en   = 1'b0;
    res_o.was_occ = occ;
    res_o.status  = pcvs_pkg::STAT_OK;
    word_o        = word_i;
    unique case (op_i)
      pcvs_pkg::REQ_CLAIM: begin
        if (!occ || (pin == '0 && !mark)) begin
          res_o.take  = 1'b1;
          res_o.wr_en = 1'b1;
          word_o      = {1'b1, 1'b0, {COUNT_BITS{1'b0}}};
        end else if (pin == '0) begin
          // second chance: drop the mark and move on
          res_o.wr_en = 1'b1;
          word_o      = {occ, 1'b0, pin};
        end
      end
      pcvs_pkg::REQ_ACQUIRE: begin
        if (&pin) begin
          res_o.status = pcvs_pkg::STAT_PIN_SAT;
        end else begin
          res_o.wr_en = 1'b1;
          word_o      = {occ, 1'b1, COUNT_BITS'(pin + 1'b1)};
        end
      end
      pcvs_pkg::REQ_RELEASE: begin
        if (pin == '0) begin
          res_o.status = pcvs_pkg::STAT_UNPINNED;
        end else begin
          res_o.wr_en = 1'b1;
          word_o      = {occ, mark, COUNT_BITS'(pin - 1'b1)};
        end
      end
      default: ;
    endcase
  end

endmodule

### design/pcvs_seq.sv
// Sequencer: clear sweep, clock hands, scan stepping and result register.
module pcvs_seq #(
  parameter int CACHE_ENTRIES = 1024,
  parameter int THREADS       = 4,
  parameter int COUNT_BITS    = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  pcvs_pkg::in_item_t               in_i,
  output logic                             in_stall_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output pcvs_pkg::out_item_t              res_o,
  output logic                             rd_en_o,
  output logic [$clog2(CACHE_ENTRIES)-1:0] rd_addr_o,
  input  logic [COUNT_BITS+1:0]            rd_data_i,
  output logic                             wr_en_o,
  output logic [$clog2(CACHE_ENTRIES)-1:0] wr_addr_o,
  output logic [COUNT_BITS+1:0]            wr_data_o
);

  localparam int IW         = $clog2(CACHE_ENTRIES);
  localparam int PART       = CACHE_ENTRIES / THREADS;
  localparam int PART_SAFE  = (PART == 0) ? 1 : PART;
  localparam int SW         = $clog2(2 * PART_SAFE + 1);
  localparam int TW         = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int STEPS_LAST = 2 * PART_SAFE - 1;

  pcvs_pkg::state_e    state_q, state_d;
  logic [IW-1:0]       clr_q;
  logic [IW-1:0]       hand_q [THREADS];
  logic [1:0]          op_q;
  logic [TW-1:0]       hsel_q, hsel_d;
  logic [IW-1:0]       cur_q, first_addr, next_addr;
  logic [IW-1:0]       base_q, base_d, last_q, last_d;
  logic [SW-1:0]       steps_q;
  pcvs_pkg::out_item_t res_q;

  logic                accept, tid_ok, tgt_ok, claim_ok, go_eval, steps_done, scan_end;
  pcvs_pkg::eval_res_t ev;
  logic [COUNT_BITS+1:0] ev_word;

  pcvs_eval #(
    .COUNT_BITS(COUNT_BITS)
  ) u_eval (
    .op_i  (op_q),
    .word_i(rd_data_i),
    .res_o (ev),
    .word_o(ev_word)
  );

  // request decode in the accept cycle
  assign accept   = in_valid_i && (state_q == pcvs_pkg::S_IDLE);
  assign tid_ok   = 32'(in_i.thread_sel) < THREADS;
  assign tgt_ok   = 32'(in_i.target_entry) < CACHE_ENTRIES;
  assign claim_ok = (in_i.req_type == pcvs_pkg::REQ_CLAIM) && tid_ok && (PART != 0);
  assign go_eval  = claim_ok || (tgt_ok && (in_i.req_type == pcvs_pkg::REQ_ACQUIRE ||
                                            in_i.req_type == pcvs_pkg::REQ_RELEASE));
  assign hsel_d   = tid_ok ? TW'(in_i.thread_sel) : '0;
  assign base_d   = IW'(32'(in_i.thread_sel) * PART);
  assign last_d   = IW'(base_d + IW'(PART_SAFE - 1));
  assign first_addr = claim_ok ? hand_q[hsel_d] : IW'(in_i.target_entry);

  assign next_addr  = (cur_q == last_q) ? base_q : IW'(cur_q + 1'b1);
  assign steps_done = steps_q == SW'(STEPS_LAST);
  assign scan_end   = (op_q != pcvs_pkg::REQ_CLAIM) || ev.take || steps_done;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pcvs_pkg::S_CLEAR: if (clr_q == IW'(CACHE_ENTRIES - 1)) state_d = pcvs_pkg::S_IDLE;
      pcvs_pkg::S_IDLE: begin
        if (accept) state_d = go_eval ? pcvs_pkg::S_EVAL : pcvs_pkg::S_DONE;
      end
      pcvs_pkg::S_READ: state_d = pcvs_pkg::S_EVAL;
      pcvs_pkg::S_EVAL: state_d = scan_end ? pcvs_pkg::S_DONE : pcvs_pkg::S_READ;
      pcvs_pkg::S_DONE: if (res_ready_i) state_d = pcvs_pkg::S_IDLE;
      default:          state_d = pcvs_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall_o  = 1'b1;
    res_valid_o = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = cur_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = cur_q;
    wr_data_o   = ev_word;
    unique case (state_q)
      pcvs_pkg::S_CLEAR: begin
        wr_en_o   = 1'b1;
        wr_addr_o = clr_q;
        wr_data_o = '0;
      end
      pcvs_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        rd_en_o    = 1'b1;
        rd_addr_o  = first_addr;
      end
      pcvs_pkg::S_READ: rd_en_o = 1'b1;
      pcvs_pkg::S_EVAL: wr_en_o = ev.wr_en;
      pcvs_pkg::S_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcvs_pkg::S_CLEAR;
      clr_q   <= '0;
      for (int t = 0; t < THREADS; t++) begin
        hand_q[t] <= IW'(t * PART);
      end
    end else begin
      state_q <= state_d;
      if (state_q == pcvs_pkg::S_CLEAR) begin
        clr_q <= IW'(clr_q + 1'b1);
      end
      if (state_q == pcvs_pkg::S_EVAL && op_q == pcvs_pkg::REQ_CLAIM) begin
        hand_q[hsel_q] <= next_addr;
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q          <= in_i.req_type;
      hsel_q        <= hsel_d;
      cur_q         <= first_addr;
      base_q        <= base_d;
      last_q        <= last_d;
      steps_q       <= '0;
      res_q.status  <= (in_i.req_type == pcvs_pkg::REQ_CLAIM) ? pcvs_pkg::STAT_NO_VICTIM
                                                             : pcvs_pkg::STAT_OK;
      res_q.victim_index        <= '0;
      res_q.victim_was_occupied <= 1'b0;
    end else if (state_q == pcvs_pkg::S_EVAL) begin
      cur_q   <= next_addr;
      steps_q <= SW'(steps_q + 1'b1);
      if (op_q != pcvs_pkg::REQ_CLAIM) begin
        res_q.status <= ev.status;
      end else if (ev.take) begin
        res_q.status              <= pcvs_pkg::STAT_OK;
        res_q.victim_index        <= 10'(cur_q);
        res_q.victim_was_occupied <= ev.was_occ;
      end
    end
  end

  assign res_o = res_q;

endmodule

### design/partitioned_clock_victim_select.sv
// Top level of the partitioned clock (second-chance) victim selector.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_i  (pcvs_pkg::in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_o (pcvs_pkg::out_item_t)
//
// One item at a time. Acquire and release read the entry, update it, then
// hand over the result to the output register. A claim examines entries one
// at a time through the entry memory (read, then evaluate and write back),
// at most 2*(CACHE_ENTRIES/THREADS) of them. After reset a clearing pass
// writes every entry with in_stall_o high. The output register lets a new
// item be accepted while the previous result is stalled; a finished item
// waits for it to drain.
module partitioned_clock_victim_select #(
  parameter int CACHE_ENTRIES = 1024,
  parameter int THREADS       = 4,
  parameter int COUNT_BITS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  pcvs_pkg::in_item_t  in_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pcvs_pkg::out_item_t out_o
);

  localparam int IW = $clog2(CACHE_ENTRIES);
  localparam int WW = COUNT_BITS + 2;

  logic                rd_en, wr_en;
  logic [IW-1:0]       rd_addr, wr_addr;
  logic [WW-1:0]       rd_data, wr_data;
  logic                res_valid, res_ready;
  pcvs_pkg::out_item_t res;

  logic                out_valid_q;
  pcvs_pkg::out_item_t out_q;

  // entry word per slot: occupied flag, read mark, pin count
  pcvs_entry_ram #(
    .DEPTH(CACHE_ENTRIES),
    .WIDTH(WW)
  ) u_ram (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  pcvs_seq #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .THREADS      (THREADS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data)
  );

  // output register: takes a result whenever it is empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // every accepted item keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted item did not make the block busy");

  // a failed (non-ok) result carries no victim
  a_no_victim_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != pcvs_pkg::STAT_OK |->
      out_o.victim_index == '0 && !out_o.victim_was_occupied)
    else $error("victim fields set on a non-ok result");

  // an evicted row is only reported with an ok status and an in-range index
  a_evict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.victim_was_occupied |->
      out_o.status == pcvs_pkg::STAT_OK && 32'(out_o.victim_index) < CACHE_ENTRIES)
    else $error("eviction reported with bad status or index");

endmodule

### bench/tb_top.sv
// Self-checking bench for the partitioned clock victim selector.
`timescale 1ns / 100ps

module tb_top;

  localparam int CACHE_ENTRIES = 1024;
  localparam int THREADS       = 4;
  localparam int COUNT_BITS    = 8;
  localparam int PART          = CACHE_ENTRIES / THREADS;
  localparam int PIN_MAX       = (1 << COUNT_BITS) - 1;

  // Request code that the block must ignore.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int STIM_ITEMS   = 1650;
  localparam int DRAIN_CYCLES = 16;
  // Worst case per item: a claim that fails after two passes over its
  // partition, plus sender gaps and receiver stalls; then a wide safety factor.
  localparam int CYCLE_LIMIT  = CACHE_ENTRIES + 3 * (STIM_ITEMS + 64) * (4 * PART + 64);

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  pcvs_pkg::in_item_t  in_i        = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pcvs_pkg::out_item_t out_o;

  partitioned_clock_victim_select #(
    .CACHE_ENTRIES(CACHE_ENTRIES),
    .THREADS      (THREADS),
    .COUNT_BITS   (COUNT_BITS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_i       (in_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the cache bookkeeping, updated as items are accepted.
  logic             held_row [CACHE_ENTRIES];
  logic [COUNT_BITS-1:0] pin_cnt [CACHE_ENTRIES];
  logic             read_bit [CACHE_ENTRIES];
  int               hand_pos [THREADS];

  pcvs_pkg::in_item_t  pending_items[$];    // items not yet presented to the block
  pcvs_pkg::out_item_t awaited_verdicts[$]; // predicted results, oldest first

  int   accepted_count = 0;
  int   result_count   = 0;
  int   mismatch_count = 0;
  int   cycle_count    = 0;
  logic calm;

  // A long stretch with no idling on either side.
  assign calm = (accepted_count >= 1200) && (accepted_count < 1450);

  // Predict the result of one request and advance the shadow state.
  function automatic pcvs_pkg::out_item_t resolve_request(pcvs_pkg::in_item_t it);
    pcvs_pkg::out_item_t r;
    int        base;
    int        e;
    int        n;
    logic      take;
    r        = '0;
    r.status = pcvs_pkg::STAT_OK;
    case (it.req_type)
      pcvs_pkg::REQ_CLAIM: begin
        base = int'(it.thread_sel) * PART;
        // At most two full passes over the partition.
        for (n = 0; n < 2 * PART; n++) begin
          e    = hand_pos[it.thread_sel];
          take = 1'b0;
          if (!held_row[e]) begin
            take = 1'b1;               // empty entry: taken at once
          end else if (pin_cnt[e] == 0) begin
            if (read_bit[e]) begin
              read_bit[e] = 1'b0;      // second chance
            end else begin
              take = 1'b1;             // idle, not recently read: evict
            end
          end
          // Hand wraps inside the partition, last slot included.
          hand_pos[it.thread_sel] = (e == base + PART - 1) ? base : e + 1;
          if (take) begin
            r.victim_index        = e[9:0];
            r.victim_was_occupied = held_row[e];
            held_row[e] = 1'b1;
            pin_cnt[e]  = '0;
            read_bit[e] = 1'b0;
            return r;
          end
        end
        r.status = pcvs_pkg::STAT_NO_VICTIM;     // hand is back at its start here
      end
      pcvs_pkg::REQ_ACQUIRE: begin
        if (pin_cnt[it.target_entry] == PIN_MAX) begin
          r.status = pcvs_pkg::STAT_PIN_SAT;
        end else begin
          pin_cnt[it.target_entry]  = pin_cnt[it.target_entry] + 1'b1;
          read_bit[it.target_entry] = 1'b1;
        end
      end
      pcvs_pkg::REQ_RELEASE: begin
        if (pin_cnt[it.target_entry] == 0) begin
          r.status = pcvs_pkg::STAT_UNPINNED;
        end else begin
          pin_cnt[it.target_entry] = pin_cnt[it.target_entry] - 1'b1;
        end
      end
      default: begin
        // unused request code: ignored, all-zero ok result
      end
    endcase
    return r;
  endfunction

  task automatic queue_item(logic [1:0] rt, logic [1:0] tid, logic [9:0] tgt);
    pcvs_pkg::in_item_t it;
    it.req_type     = rt;
    it.thread_sel   = tid;
    it.target_entry = tgt;
    pending_items.push_back(it);
  endtask

  task automatic report_mismatch(string what, int got_v, int want_v);
    $display("mismatch on result %0d: %s got %0d expected %0d",
             result_count, what, got_v, want_v);
    mismatch_count++;
  endtask

  // Driver: present the next item when the slot is free; prediction happens
  // at the edge where the block takes the item.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        awaited_verdicts.push_back(resolve_request(in_i));
        accepted_count <= accepted_count + 1;
      end
      // Payload only changes once the current item is gone.
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
          in_i       <= pending_items.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, and field-by-field check of each result.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 34);
      if (out_valid_o && !out_stall_i) begin
        if (awaited_verdicts.size() == 0) begin
          report_mismatch("unexpected result, status", int'(out_o.status), -1);
        end else begin
          if (out_o.status !== awaited_verdicts[0].status)
            report_mismatch("status", int'(out_o.status),
                            int'(awaited_verdicts[0].status));
          if (out_o.victim_index !== awaited_verdicts[0].victim_index)
            report_mismatch("victim_index", int'(out_o.victim_index),
                            int'(awaited_verdicts[0].victim_index));
          if (out_o.victim_was_occupied !== awaited_verdicts[0].victim_was_occupied)
            report_mismatch("victim_was_occupied", int'(out_o.victim_was_occupied),
                            int'(awaited_verdicts[0].victim_was_occupied));
          void'(awaited_verdicts.pop_front());
        end
        result_count <= result_count + 1;
      end
    end
  end

  // Watchdog; covers the clearing pass after reset too.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** partitioned_clock_victim_select: FAILED **");
      $finish;
    end
  end

  initial begin
    int         s;
    int         base;
    int         off;
    int         pick;
    logic [9:0] x;
    logic [9:0] tgt;
    logic [9:0] recent[$];

    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      held_row[i] = 1'b0;
      pin_cnt[i]  = '0;
      read_bit[i] = 1'b0;
    end
    for (int t = 0; t < THREADS; t++) hand_pos[t] = t * PART;

    // ---- directed part ----
    // First claim of every thread lands on its empty partition start.
    for (int t = 0; t < THREADS; t++)
      queue_item(pcvs_pkg::REQ_CLAIM, t[1:0], 10'($urandom));
    // Pin twice, unpin twice, then unpin an idle entry.
    queue_item(pcvs_pkg::REQ_ACQUIRE, 2'd1, 10'd0);
    queue_item(pcvs_pkg::REQ_ACQUIRE, 2'd2, 10'd0);
    queue_item(pcvs_pkg::REQ_RELEASE, 2'd0, 10'd0);
    queue_item(pcvs_pkg::REQ_RELEASE, 2'd3, 10'd0);
    queue_item(pcvs_pkg::REQ_RELEASE, 2'd0, 10'd0);
    // Top entry, never claimed: occupancy is not checked on pin or unpin.
    queue_item(pcvs_pkg::REQ_ACQUIRE, 2'd3, 10'h3FF);
    queue_item(pcvs_pkg::REQ_RELEASE, 2'd3, 10'h3FF);
    // A pinned but empty entry is still taken, and its pin count cleared.
    queue_item(pcvs_pkg::REQ_ACQUIRE, 2'd0, 10'd770);
    queue_item(pcvs_pkg::REQ_CLAIM,   2'd3, 10'h000);
    queue_item(pcvs_pkg::REQ_CLAIM,   2'd3, 10'h3FF);
    queue_item(pcvs_pkg::REQ_RELEASE, 2'd1, 10'd770);
    // Unused request code, all ones and all zeros.
    queue_item(REQ_UNUSED, 2'd3, 10'h3FF);
    queue_item(REQ_UNUSED, 2'd0, 10'h000);
    // Alternating target bit patterns.
    queue_item(pcvs_pkg::REQ_ACQUIRE, 2'd2, 10'h155);
    queue_item(pcvs_pkg::REQ_ACQUIRE, 2'd1, 10'h2AA);
    queue_item(pcvs_pkg::REQ_RELEASE, 2'd2, 10'h155);
    queue_item(pcvs_pkg::REQ_RELEASE, 2'd1, 10'h2AA);

    // ---- structured random part ----
    // Fill one partition, pin all of it (no victim), unpin all of it, then
    // claim again: a whole pass of second chances before a take.
    s    = $urandom_range(THREADS - 1);
    base = s * PART;
    off  = $urandom_range(PART - 1);
    for (int k = 0; k < PART + 4; k++)
      queue_item(pcvs_pkg::REQ_CLAIM, s[1:0], 10'($urandom));
    for (int k = 0; k < PART; k++)
      queue_item(pcvs_pkg::REQ_ACQUIRE, 2'($urandom), 10'(base + (k + off) % PART));
    queue_item(pcvs_pkg::REQ_CLAIM, s[1:0], 10'($urandom));
    queue_item(pcvs_pkg::REQ_CLAIM, s[1:0], 10'($urandom));
    queue_item(pcvs_pkg::REQ_CLAIM, 2'((s + 1) % THREADS), 10'($urandom));
    for (int k = 0; k < PART; k++)
      queue_item(pcvs_pkg::REQ_RELEASE, 2'($urandom), 10'(base + (k + off + 7) % PART));
    for (int k = 0; k < 3; k++)
      queue_item(pcvs_pkg::REQ_CLAIM, s[1:0], 10'($urandom));

    // Pin count saturation on one random entry.
    x = 10'($urandom);
    for (int k = 0; k <= PIN_MAX; k++) queue_item(pcvs_pkg::REQ_ACQUIRE, 2'($urandom), x);
    for (int k = 0; k < 3; k++) queue_item(pcvs_pkg::REQ_RELEASE, 2'($urandom), x);

    // Mixed traffic; pins and unpins favor recently pinned entries.
    while (pending_items.size() < STIM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        queue_item(pcvs_pkg::REQ_CLAIM, 2'($urandom), 10'($urandom));
      end else if (pick < 95) begin
        tgt = 10'($urandom);
        if (recent.size() > 0 && $urandom_range(1))
          tgt = recent[$urandom_range(recent.size() - 1)];
        if (pick < 70) begin
          queue_item(pcvs_pkg::REQ_ACQUIRE, 2'($urandom), tgt);
          recent.push_back(tgt);
          if (recent.size() > 16) void'(recent.pop_front());
        end else begin
          queue_item(pcvs_pkg::REQ_RELEASE, 2'($urandom), tgt);
        end
      end else begin
        queue_item(REQ_UNUSED, 2'($urandom), 10'($urandom));
      end
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // All items taken, all results back, then a short quiet tail.
    while (pending_items.size() != 0 || in_valid_i) @(posedge clk_i);
    while (awaited_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("** partitioned_clock_victim_select: PASSED **");
    end else begin
      $display("** partitioned_clock_victim_select: FAILED **");
    end
    $finish;
  end

endmodule
